[hdl/assert_macros.svh]
// Assertion macros shared by the pan/tilt position mover RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/tpm_pkg.sv]
// Shared types, codes and constants of the pan/tilt position mover.
// No dependencies; tpm_step and the top module import this package.
package tpm_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int NULL_SLOT  = 21;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W    = 32;

  localparam logic [15:0] FULL_TURN = 16'd36000;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_TEACH,
    ACT_MOVE,
    ACT_JOG
  } action_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MOVING,
    MS_ARRIVED,
    MS_TIMEOUT
  } status_t;

  localparam logic [2:0] BTN_UP    = 3'd1;
  localparam logic [2:0] BTN_DOWN  = 3'd2;
  localparam logic [2:0] BTN_RIGHT = 3'd3;
  localparam logic [2:0] BTN_LEFT  = 3'd4;

  localparam logic [1:0] CFG_DEADBAND = 2'd0;
  localparam logic [1:0] CFG_PAN_MIN  = 2'd1;
  localparam logic [1:0] CFG_PAN_MAX  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd3;

  localparam logic [9:0]  DEADBAND_RST = 10'd50;
  localparam logic [15:0] PAN_MIN_RST  = 16'd1000;
  localparam logic [15:0] PAN_MAX_RST  = 16'd35000;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1714;

  // Relay vector bit positions.
  localparam int R_UP    = 0;
  localparam int R_DOWN  = 1;
  localparam int R_RIGHT = 2;
  localparam int R_LEFT  = 3;
  localparam int R_LOCK  = 4;

  // Axis bit positions.
  localparam int AX_TILT = 0;
  localparam int AX_PAN  = 1;

  typedef struct packed {
    logic [1:0]         action;
    logic [4:0]         slot;
    logic [15:0]        pan_raw;
    logic signed [15:0] tilt_raw;
    logic [2:0]         button;
  } item_t;

  typedef struct packed {
    logic [9:0]  deadband;
    logic [15:0] pan_min;
    logic [15:0] pan_max;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pan_offset;
    logic [1:0]  axis_active;
    logic [1:0]  axis_dir;
    logic [31:0] target;
    logic [15:0] tick;
    logic [4:0]  relay;
    status_t     status;
  } mv_state_t;

  typedef struct packed {
    logic [4:0]  relay;
    logic [1:0]  move_status;
    logic [15:0] pan_relative;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    logic [ENTRY_W-1:0] data;
  } tbl_wr_t;

endpackage

[hdl/tpm_if.sv]
// Valid/ready channel interfaces for input items and result beats.
// Standalone; payload fields use the widths of the package types.
interface tpm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [4:0]         slot;
  logic [15:0]        pan_raw;
  logic signed [15:0] tilt_raw;
  logic [2:0]         button;

  modport source(output valid, action, slot, pan_raw, tilt_raw, button, input ready);
  modport sink(input valid, action, slot, pan_raw, tilt_raw, button, output ready);
endinterface

interface tpm_out_if;
  logic        valid;
  logic        ready;
  logic        relay_tilt_up;
  logic        relay_tilt_down;
  logic        relay_pan_right;
  logic        relay_pan_left;
  logic        relay_lock;
  logic [1:0]  move_status;
  logic [15:0] pan_relative;

  modport source(output valid, relay_tilt_up, relay_tilt_down, relay_pan_right,
                 relay_pan_left, relay_lock, move_status, pan_relative, input ready);
  modport sink(input valid, relay_tilt_up, relay_tilt_down, relay_pan_right,
               relay_pan_left, relay_lock, move_status, pan_relative, output ready);
endinterface

[hdl/tpm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tpm_step.sv]
// Next-state and result logic for one item: tick, teach, move or jog.
// Depends on tpm_pkg; the table entry comes from the position RAM.
module tpm_step
  import tpm_pkg::*;
(
  input  item_t              item,
  input  logic [ENTRY_W-1:0] entry,
  input  mv_state_t          st,
  input  cfg_t               cfg,
  output mv_state_t          st_nxt,
  output tbl_wr_t            tbl_wr,
  output result_t            res
);

  always_comb begin
    logic [16:0]        diff;
    logic [15:0]        pcur;
    logic signed [15:0] tcur;
    logic signed [15:0] tt_l;
    logic [15:0]        pt_l;
    logic signed [15:0] tt_e;
    logic [15:0]        pt_e;
    logic signed [16:0] t_err;
    logic [16:0]        t_abs;
    logic signed [17:0] p_err;
    logic [17:0]        p_abs;
    logic               busy;
    logic               slot_ok;
    logic               is_null;
    logic               rel_zero;

    diff     = {1'b0, item.pan_raw} - {1'b0, st.pan_offset};
    pcur     = diff[16] ? diff[15:0] + FULL_TURN : diff[15:0];
    tcur     = item.tilt_raw;
    tt_l     = st.target[31:16];
    pt_l     = st.target[15:0];
    tt_e     = entry[31:16];
    pt_e     = entry[15:0];
    t_err    = {tt_e[15], tt_e} - {tcur[15], tcur};
    t_abs    = t_err[16] ? 17'(-t_err) : 17'(t_err);
    p_err    = $signed({2'b00, pt_e}) - $signed({2'b00, pcur});
    p_abs    = p_err[17] ? 18'(-p_err) : 18'(p_err);
    busy     = |st.axis_active;
    slot_ok  = int'(item.slot) < SLOT_COUNT;
    is_null  = int'(item.slot) == NULL_SLOT;
    rel_zero = 1'b0;

    st_nxt = st;
    tbl_wr = '0;

    unique case (action_t'(item.action))
      ACT_TICK: begin
        if (busy) begin
          if (st.tick >= cfg.timeout_ticks) begin
            st_nxt.axis_active = '0;
            st_nxt.relay       = '0;
            st_nxt.status      = MS_TIMEOUT;
          end else begin
            if (st.axis_active[AX_TILT] &&
                (st.axis_dir[AX_TILT] ? (tt_l <= tcur) : (tt_l >= tcur))) begin
              st_nxt.relay[R_UP]         = 1'b0;
              st_nxt.relay[R_DOWN]       = 1'b0;
              st_nxt.axis_active[AX_TILT] = 1'b0;
            end
            if (st.axis_active[AX_PAN] &&
                (st.axis_dir[AX_PAN] ? (pt_l <= pcur) : (pt_l >= pcur))) begin
              st_nxt.relay[R_RIGHT]      = 1'b0;
              st_nxt.relay[R_LEFT]       = 1'b0;
              st_nxt.axis_active[AX_PAN] = 1'b0;
            end
            st_nxt.tick = st.tick + 16'd1;
            if (st_nxt.axis_active == '0) begin
              st_nxt.relay  = '0;
              st_nxt.status = MS_ARRIVED;
            end
          end
        end
      end
      ACT_TEACH: begin
        if (slot_ok) begin
          tbl_wr.en   = 1'b1;
          tbl_wr.addr = SLOT_AW'(item.slot);
          tbl_wr.data = {tcur, (is_null ? item.pan_raw : pcur)};
          if (is_null) begin
            st_nxt.pan_offset = item.pan_raw;
            rel_zero          = 1'b1;
          end
        end
      end
      ACT_MOVE: begin
        if (!busy && slot_ok) begin
          st_nxt.target      = entry;
          st_nxt.tick        = '0;
          st_nxt.axis_dir    = '0;
          st_nxt.axis_active = '0;
          st_nxt.relay       = '0;
          st_nxt.relay[R_LOCK] = 1'b1;
          if (t_abs > {7'd0, cfg.deadband}) begin
            st_nxt.axis_active[AX_TILT] = 1'b1;
            if (tt_e > tcur) begin
              st_nxt.relay[R_DOWN]     = 1'b1;
              st_nxt.axis_dir[AX_TILT] = 1'b1;
            end else begin
              st_nxt.relay[R_UP] = 1'b1;
            end
          end
          if (p_abs > {8'd0, cfg.deadband} && pt_e > cfg.pan_min && pt_e < cfg.pan_max) begin
            st_nxt.axis_active[AX_PAN] = 1'b1;
            if (pt_e > pcur) begin
              st_nxt.relay[R_RIGHT]   = 1'b1;
              st_nxt.axis_dir[AX_PAN] = 1'b1;
            end else begin
              st_nxt.relay[R_LEFT] = 1'b1;
            end
          end
          if (st_nxt.axis_active == '0) begin
            st_nxt.relay  = '0;
            st_nxt.status = MS_ARRIVED;
          end else begin
            st_nxt.status = MS_MOVING;
          end
        end
      end
      ACT_JOG: begin
        if (!busy) begin
          st_nxt.status = MS_IDLE;
          unique case (item.button)
            BTN_UP: begin
              st_nxt.relay[R_DOWN] = 1'b0;
              st_nxt.relay[R_UP]   = 1'b1;
              st_nxt.relay[R_LOCK] = 1'b1;
            end
            BTN_DOWN: begin
              st_nxt.relay[R_UP]   = 1'b0;
              st_nxt.relay[R_DOWN] = 1'b1;
              st_nxt.relay[R_LOCK] = 1'b1;
            end
            BTN_RIGHT: begin
              st_nxt.relay[R_LEFT]  = 1'b0;
              st_nxt.relay[R_RIGHT] = 1'b1;
              st_nxt.relay[R_LOCK]  = 1'b1;
            end
            BTN_LEFT: begin
              st_nxt.relay[R_RIGHT] = 1'b0;
              st_nxt.relay[R_LEFT]  = 1'b1;
              st_nxt.relay[R_LOCK]  = 1'b1;
            end
            default: begin
              st_nxt.relay = '0;
            end
          endcase
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.relay        = st_nxt.relay;
    res.move_status  = (|st_nxt.axis_active) ? MS_MOVING : st_nxt.status;
    res.pan_relative = rel_zero ? 16'd0 : pcur;
  end

endmodule

[hdl/two_axis_teach_position_mover.sv]
// Flow: an item is accepted only in S_IDLE; the position RAM read of its slot
// precedes the update in S_EXEC, where the result beat is registered when the
// update commits, and a full result register holds the update until it is taken.
// Reset: synchronous active-low rst_n clears control state, the move state and the
// per-entry table valid bits at once, and loads the register defaults.
// Depends on tpm_pkg, tpm_if, tpm_ram, tpm_step and assert_macros.svh.
`include "assert_macros.svh"
module two_axis_teach_position_mover
  import tpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tpm_in_if.sink           in_ch,
  tpm_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);

  typedef enum logic {S_IDLE, S_EXEC} fsm_t;

  fsm_t               state_r;
  item_t              item_r;
  cfg_t               cfg_r;
  mv_state_t          st_r;
  mv_state_t          st_nxt;
  logic [SLOT_COUNT-1:0] valid_r;
  logic               out_valid_r;
  result_t            res_r;
  result_t            res_nxt;
  tbl_wr_t            tbl_wr;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry;
  logic [SLOT_AW-1:0] rd_idx;
  logic               in_acc;
  logic               commit;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign rd_idx      = SLOT_AW'(item_r.slot);
  assign entry       = valid_r[rd_idx] ? rd_data : '0;

  tpm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (commit && tbl_wr.en),
    .waddr(tbl_wr.addr),
    .wdata(tbl_wr.data),
    .re   (in_acc),
    .raddr(SLOT_AW'(in_ch.slot)),
    .rdata(rd_data)
  );

  tpm_step u_step (
    .item  (item_r),
    .entry (entry),
    .st    (st_r),
    .cfg   (cfg_r),
    .st_nxt(st_nxt),
    .tbl_wr(tbl_wr),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= {in_ch.action, in_ch.slot, in_ch.pan_raw, in_ch.tilt_raw, in_ch.button};
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband      <= DEADBAND_RST;
      cfg_r.pan_min       <= PAN_MIN_RST;
      cfg_r.pan_max       <= PAN_MAX_RST;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEADBAND: cfg_r.deadband      <= cfg_wdata[9:0];
        CFG_PAN_MIN:  cfg_r.pan_min       <= cfg_wdata;
        CFG_PAN_MAX:  cfg_r.pan_max       <= cfg_wdata;
        CFG_TIMEOUT:  cfg_r.timeout_ticks <= cfg_wdata;
        default:      cfg_r               <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            st_r        <= st_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (tbl_wr.en) begin
              valid_r[tbl_wr.addr] <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.relay_tilt_up   = res_r.relay[R_UP];
  assign out_ch.relay_tilt_down = res_r.relay[R_DOWN];
  assign out_ch.relay_pan_right = res_r.relay[R_RIGHT];
  assign out_ch.relay_pan_left  = res_r.relay[R_LEFT];
  assign out_ch.relay_lock      = res_r.relay[R_LOCK];
  assign out_ch.move_status     = res_r.move_status;
  assign out_ch.pan_relative    = res_r.pan_relative;

  `ASSERT_IMP(a_tilt_excl, clk, rst_n, 1'b1, !(st_r.relay[R_UP] && st_r.relay[R_DOWN]))
  `ASSERT_IMP(a_pan_excl, clk, rst_n, 1'b1, !(st_r.relay[R_RIGHT] && st_r.relay[R_LEFT]))
  `ASSERT_IMP(a_move_lock, clk, rst_n, |st_r.axis_active, st_r.relay[R_LOCK])
  `ASSERT_IMP(a_dir_lock, clk, rst_n, |st_r.relay[R_LEFT:R_UP], st_r.relay[R_LOCK])
  `ASSERT_NXT(a_acc_exec, clk, rst_n, in_acc, state_r == S_EXEC)
  `ASSERT_NXT(a_commit_out, clk, rst_n, commit, out_valid_r)

endmodule
